### rtl/core/blir_pkg.sv
// ----------------------------------------------------------------------------
// blir_pkg
// Shared constants and types for the bounded ordered list block.
// ----------------------------------------------------------------------------
package blir_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int VALUE_W      = 32;
	localparam int OP_W         = 2;
	localparam int CNT_OUT_W    = 5;

	localparam logic [OP_W-1:0] OP_FRONT  = 2'd0;
	localparam logic [OP_W-1:0] OP_BACK   = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	typedef struct packed {
		logic                 ok;
		logic [CNT_OUT_W-1:0] removed_count;
		logic [CNT_OUT_W-1:0] length;
	} res_t;

endpackage

### rtl/core/blir_ram.sv
// ----------------------------------------------------------------------------
// blir_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module blir_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/blir_seq.sv
// ----------------------------------------------------------------------------
// blir_seq
// List sequencer: head/count registers, inserts, and the compacting remove
// walk over the entry RAM (read one entry a cycle, write back survivors).
// ----------------------------------------------------------------------------
module blir_seq #(
	parameter int CAPACITY = blir_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [blir_pkg::OP_W-1:0]     operation,
	input  logic signed [blir_pkg::VALUE_W-1:0] value,
	output logic                          res_valid,
	input  logic                          res_ready,
	output blir_pkg::res_t                res
);

	localparam int SLOT_W  = $clog2(CAPACITY);
	localparam int COUNT_W = $clog2(CAPACITY + 1);
	localparam int SUM_W   = COUNT_W + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_RESP
	} state_t;

	state_t                       state_q;
	logic [SLOT_W-1:0]            head_q;
	logic [COUNT_W-1:0]           cnt_q;
	logic [COUNT_W-1:0]           rpos_q;
	logic [COUNT_W-1:0]           kept_q;
	logic                         chk_s1;
	logic [blir_pkg::VALUE_W-1:0] match_q;
	blir_pkg::res_t               res_q;

	logic                         acc;
	logic                         not_full;
	logic                         rd_more;
	logic                         keep;
	logic [SLOT_W-1:0]            front_slot;
	logic                         we;
	logic [SLOT_W-1:0]            waddr;
	logic [blir_pkg::VALUE_W-1:0] wdata;
	logic                         re;
	logic [SLOT_W-1:0]            raddr;
	logic [blir_pkg::VALUE_W-1:0] rdata;

	function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] head,
		input logic [COUNT_W-1:0] pos);
		logic [SUM_W-1:0] sum;
		logic [SUM_W-1:0] wrapped;
		sum = SUM_W'(head) + SUM_W'(pos);
		wrapped = (sum >= SUM_W'(CAPACITY)) ? sum - SUM_W'(CAPACITY) : sum;
		return wrapped[SLOT_W-1:0];
	endfunction

	function automatic logic [blir_pkg::CNT_OUT_W-1:0] fit_cnt(
		input logic [COUNT_W-1:0] x);
		logic [COUNT_W+blir_pkg::CNT_OUT_W-1:0] ext;
		ext = (COUNT_W + blir_pkg::CNT_OUT_W)'(x);
		return ext[blir_pkg::CNT_OUT_W-1:0];
	endfunction

	assign acc        = req_valid && (state_q == S_IDLE);
	assign req_stall  = (state_q != S_IDLE);
	assign not_full   = (cnt_q < COUNT_W'(CAPACITY));
	assign rd_more    = (state_q == S_WALK) && (rpos_q < cnt_q);
	assign keep       = chk_s1 && (rdata != match_q);
	assign front_slot = (head_q == '0) ? SLOT_W'(CAPACITY - 1) : head_q - SLOT_W'(1);
	assign res_valid  = (state_q == S_RESP);
	assign res        = res_q;

	always_comb begin
		we    = 1'b0;
		waddr = slot_of(head_q, kept_q);
		wdata = rdata;
		re    = rd_more;
		raddr = slot_of(head_q, rpos_q);
		if (state_q == S_WALK) begin
			we = keep;
		end else if (acc && not_full) begin
			case (operation)
				blir_pkg::OP_FRONT: begin
					we    = 1'b1;
					waddr = front_slot;
					wdata = value;
				end
				blir_pkg::OP_BACK: begin
					we    = 1'b1;
					waddr = slot_of(head_q, cnt_q);
					wdata = value;
				end
				default: begin
					we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			cnt_q   <= '0;
			rpos_q  <= '0;
			kept_q  <= '0;
			chk_s1  <= 1'b0;
			match_q <= '0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						res_q.removed_count <= '0;
						case (operation)
							blir_pkg::OP_FRONT: begin
								state_q  <= S_RESP;
								res_q.ok <= not_full;
								if (not_full) begin
									head_q       <= front_slot;
									cnt_q        <= cnt_q + COUNT_W'(1);
									res_q.length <= fit_cnt(cnt_q + COUNT_W'(1));
								end else begin
									res_q.length <= fit_cnt(cnt_q);
								end
							end
							blir_pkg::OP_BACK: begin
								state_q  <= S_RESP;
								res_q.ok <= not_full;
								if (not_full) begin
									cnt_q        <= cnt_q + COUNT_W'(1);
									res_q.length <= fit_cnt(cnt_q + COUNT_W'(1));
								end else begin
									res_q.length <= fit_cnt(cnt_q);
								end
							end
							blir_pkg::OP_REMOVE: begin
								match_q <= value;
								rpos_q  <= '0;
								kept_q  <= '0;
								chk_s1  <= 1'b0;
								state_q <= S_WALK;
							end
							default: begin
								state_q      <= S_RESP;
								res_q.ok     <= 1'b0;
								res_q.length <= fit_cnt(cnt_q);
							end
						endcase
					end
				end
				S_WALK: begin
					chk_s1 <= rd_more;
					if (rd_more) begin
						rpos_q <= rpos_q + COUNT_W'(1);
					end
					if (keep) begin
						kept_q <= kept_q + COUNT_W'(1);
					end
					if (!rd_more && !chk_s1) begin
						cnt_q               <= kept_q;
						res_q.ok            <= 1'b1;
						res_q.removed_count <= fit_cnt(cnt_q - kept_q);
						res_q.length        <= fit_cnt(kept_q);
						state_q             <= S_RESP;
					end
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	blir_ram #(
		.WIDTH (blir_pkg::VALUE_W),
		.DEPTH (CAPACITY),
		.ADDR_W(SLOT_W)
	) u_entries (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

`ifndef SYNTHESIS
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(we && re) |-> (waddr != raddr))
		else $error("entry RAM read and write hit the same slot");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= COUNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_kept_behind_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (kept_q <= rpos_q))
		else $error("compaction write pointer passed read pointer");

	a_head_moves_on_front: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(head_q) |-> $past(acc && (operation == blir_pkg::OP_FRONT)))
		else $error("head moved without a front insert");
`endif

endmodule

### rtl/core/bounded_list_insert_remove.sv
// ----------------------------------------------------------------------------
// bounded_list_insert_remove
// Ordered list of signed 32-bit values with fixed capacity, insert/remove-all.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_stall, operation, value): a transaction is
//   taken when req_valid is high and req_stall is low. Operations: insert at
//   front, insert at back, remove every entry equal to value.
//   Response channel (rsp_valid/rsp_stall, ok, removed_count, length): one
//   transaction per request, in order.
//   An insert is registered in the sequencer's result register and then
//   moved to the output register. A remove walks the stored entries
//   through the entry RAM, one read a cycle with survivors written back
//   behind the read pointer, before its result is registered the same way.
//   The next request is taken the cycle after the result leaves the
//   sequencer, so requests are handled one at a time.
//   Reset empties the list at once (head and count cleared); the entry RAM is
//   not cleared.
//   A stalled response holds in the output register; one more result can
//   wait in the sequencer, after which req_stall stays high.
// ----------------------------------------------------------------------------
module bounded_list_insert_remove #(
	parameter int CAPACITY = blir_pkg::CAPACITY_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  logic [blir_pkg::OP_W-1:0]            operation,
	input  logic signed [blir_pkg::VALUE_W-1:0]  value,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output logic                                 ok,
	output logic [blir_pkg::CNT_OUT_W-1:0]       removed_count,
	output logic [blir_pkg::CNT_OUT_W-1:0]       length
);

	logic           res_valid;
	logic           res_ready;
	blir_pkg::res_t res;
	logic           out_vld_q;
	blir_pkg::res_t out_q;

	assign res_ready = !out_vld_q || !rsp_stall;

	blir_seq #(
		.CAPACITY(CAPACITY)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.operation(operation),
		.value    (value),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign rsp_valid     = out_vld_q;
	assign ok            = out_q.ok;
	assign removed_count = out_q.removed_count;
	assign length        = out_q.length;

endmodule

### sim/list_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// list_checker
// Watches the request and response channels of the bounded ordered list,
// keeps its own copy of the list contents to predict every response, and
// compares each response field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module list_checker
	import blir_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	input  logic                        req_stall,
	input  logic [OP_W-1:0]             operation,
	input  logic signed [VALUE_W-1:0]   value,
	input  logic                        rsp_valid,
	input  logic                        rsp_stall,
	input  logic                        ok,
	input  logic [CNT_OUT_W-1:0]        removed_count,
	input  logic [CNT_OUT_W-1:0]        length,
	output int                          mismatch_count,
	output int                          outstanding
);

	logic [VALUE_W-1:0] list_vals[$];
	res_t               pending_results[$];
	int                 errs = 0;

	function automatic res_t predict_list_op(input logic [OP_W-1:0] op,
	                                         input logic [VALUE_W-1:0] v);
		res_t               r;
		logic [VALUE_W-1:0] survivors[$];
		int                 dropped;
		r = '0;
		dropped = 0;
		case (op)
			OP_FRONT, OP_BACK: begin
				if (list_vals.size() < CAPACITY_DEF) begin
					if (op == OP_FRONT)
						list_vals.push_front(v);
					else
						list_vals.push_back(v);
					r.ok = 1'b1;
				end
			end
			OP_REMOVE: begin
				foreach (list_vals[i]) begin
					if (list_vals[i] != v)
						survivors.push_back(list_vals[i]);
					else
						dropped++;
				end
				list_vals = survivors;
				r.ok = 1'b1;
				r.removed_count = CNT_OUT_W'(dropped);
			end
			default: ;
		endcase
		r.length = CNT_OUT_W'(list_vals.size());
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		res_t want;
		if (!arst_n) begin
			list_vals.delete();
			pending_results.delete();
			mismatch_count <= 0;
			outstanding <= 0;
		end else begin
			// response first: it always belongs to an earlier transaction
			if (rsp_valid && !rsp_stall) begin
				if (pending_results.size() == 0) begin
					errs++;
					$error("response transaction with no request pending");
				end else begin
					want = pending_results.pop_front();
					if (ok !== want.ok) begin
						errs++;
						$error("ok: expected %0d, got %0d", want.ok, ok);
					end
					if (removed_count !== want.removed_count) begin
						errs++;
						$error("removed_count: expected %0d, got %0d",
						       want.removed_count, removed_count);
					end
					if (length !== want.length) begin
						errs++;
						$error("length: expected %0d, got %0d", want.length, length);
					end
				end
			end
			if (req_valid && !req_stall)
				pending_results.push_back(predict_list_op(operation, value));
			mismatch_count <= errs;
			outstanding <= pending_results.size();
		end
	end

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the bounded ordered list: directed corner cases
// (empty, full, extreme values, unused opcode), then random segments that
// fill, drain or mix the list, with random gaps and response backpressure.
// ----------------------------------------------------------------------------
module testbench;
	import blir_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
	localparam int              STALL_LIMIT = 3000;
	localparam int              SEGMENTS    = 20;
	localparam int              SEG_ITEMS   = 34;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      req_valid = 1'b0;
	logic                      req_stall;
	logic [OP_W-1:0]           operation = '0;
	logic signed [VALUE_W-1:0] value = '0;
	logic                      rsp_valid;
	logic                      rsp_stall = 1'b0;
	logic                      ok;
	logic [CNT_OUT_W-1:0]      removed_count;
	logic [CNT_OUT_W-1:0]      length;
	int                        mismatch_count;
	int                        outstanding;

	logic [VALUE_W-1:0] value_pool[5] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0,
	                                      32'hffff_ffff, 32'h0000_04d2};

	always #2 clk = ~clk;

	bounded_list_insert_remove u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.operation    (operation),
		.value        (value),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.ok           (ok),
		.removed_count(removed_count),
		.length       (length)
	);

	list_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.operation     (operation),
		.value         (value),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.ok            (ok),
		.removed_count (removed_count),
		.length        (length),
		.mismatch_count(mismatch_count),
		.outstanding   (outstanding)
	);

	function automatic logic [VALUE_W-1:0] pick_value(input int pool_pct);
		if ($urandom_range(0, 99) < pool_pct)
			return value_pool[$urandom_range(0, 4)];
		return $urandom;
	endfunction

	// called at a falling edge; returns at a falling edge
	task automatic issue_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] v,
	                             input bit quiet);
		int r;
		int gap;
		operation <= op;
		value <= v;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
		r = $urandom_range(0, 99);
		gap = 0;
		if (!quiet) begin
			if (r >= 90)
				gap = $urandom_range(8, 40);
			else if (r >= 55)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	initial begin : rsp_backpressure
		int r;
		int run;
		forever begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				rsp_stall <= 1'b0;
				run = $urandom_range(1, 20);
			end else if (r < 92) begin
				rsp_stall <= 1'b1;
				run = $urandom_range(1, 3);
			end else begin
				rsp_stall <= 1'b1;
				run = $urandom_range(10, 30);
			end
			repeat (run) @(negedge clk);
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle = 0;
			else
				idle++;
		end
		$display("[bounded_list_insert_remove] ERROR");
		$finish;
	end

	initial begin : stimulus
		int  seg;
		int  k;
		int  mode;
		int  r;
		bit  quiet;
		logic [OP_W-1:0] op;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty list, extremes, no-match remove, fill, full, unused opcode
		quiet = 1'b0;
		issue_request(OP_REMOVE, 32'h0, quiet);
		issue_request(OP_UNUSED, 32'h0, quiet);
		issue_request(OP_FRONT, 32'h8000_0000, quiet);
		issue_request(OP_BACK, 32'h7fff_ffff, quiet);
		issue_request(OP_FRONT, 32'h0, quiet);
		issue_request(OP_BACK, 32'hffff_ffff, quiet);
		issue_request(OP_REMOVE, 32'h5, quiet);
		issue_request(OP_REMOVE, 32'h8000_0000, quiet);
		for (k = 0; k < 13; k++)
			issue_request((k % 2) ? OP_BACK : OP_FRONT, 32'h7, quiet);
		issue_request(OP_FRONT, 32'h1, quiet);
		issue_request(OP_BACK, 32'h1, quiet);
		issue_request(OP_UNUSED, 32'hffff_ffff, quiet);
		issue_request(OP_REMOVE, 32'h7, quiet);

		// random: fill-heavy, drain-heavy and mixed segments
		for (seg = 0; seg < SEGMENTS; seg++) begin
			mode = $urandom_range(0, 2);
			quiet = ($urandom_range(0, 3) == 0);
			for (k = 0; k < SEG_ITEMS; k++) begin
				r = $urandom_range(0, 99);
				case (mode)
					0:       op = (r < 40) ? OP_FRONT : (r < 80) ? OP_BACK :
					              (r < 97) ? OP_REMOVE : OP_UNUSED;
					1:       op = (r < 20) ? OP_FRONT : (r < 40) ? OP_BACK :
					              (r < 95) ? OP_REMOVE : OP_UNUSED;
					default: op = (r < 30) ? OP_FRONT : (r < 60) ? OP_BACK :
					              (r < 96) ? OP_REMOVE : OP_UNUSED;
				endcase
				issue_request(op, pick_value((op == OP_REMOVE) ? 85 : 60), quiet);
			end
		end
		req_valid <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && outstanding == 0)
			$display("[bounded_list_insert_remove] OK");
		else
			$display("[bounded_list_insert_remove] ERROR");
		$finish;
	end

endmodule

### files.f
rtl/core/blir_pkg.sv
rtl/core/blir_ram.sv
rtl/core/blir_seq.sv
rtl/core/bounded_list_insert_remove.sv
sim/list_checker.sv
sim/testbench.sv
